// ----- design/ttop_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttop_pkg
// Shared types and constants of the one-shot/periodic timer table.
// ----------------------------------------------------------------------------
package ttop_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int TIME_W     = 32;
	localparam int ID_W       = 32;

	typedef enum logic [2:0] {
		CMD_CREATE_ONESHOT  = 3'd0,
		CMD_CREATE_PERIODIC = 3'd1,
		CMD_CANCEL          = 3'd2,
		CMD_TICK            = 3'd3,
		CMD_CLEAR           = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_CREATED = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_FIRED   = 3'd2,
		KIND_NONE    = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] start;
		logic              scaled;
		logic              periodic;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

// ----- design/ttop_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttop_req_if / ttop_rsp_if
// Valid/ready channels for timer commands and their results.
// ----------------------------------------------------------------------------
interface ttop_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] delay;
	logic        use_scaled;
	logic [31:0] target_id;
	logic [31:0] now_unscaled;
	logic [31:0] now_scaled;

	modport source (output valid, cmd, delay, use_scaled, target_id, now_unscaled,
		now_scaled, input ready);
	modport sink (input valid, cmd, delay, use_scaled, target_id, now_unscaled,
		now_scaled, output ready);
endinterface

interface ttop_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] timer_id;
	logic        last;

	modport source (output valid, kind, timer_id, last, input ready);
	modport sink (input valid, kind, timer_id, last, output ready);
endinterface

// ----- design/ttop_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttop_ram
// Simple dual-port RAM: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module ttop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/ttop_expire.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttop_expire
// Shared expiry compare: picks the entry's time base, forms the wrapped
// elapsed time and compares it against the period.
// ----------------------------------------------------------------------------
module ttop_expire (
	input  ttop_pkg::slot_t               slot,
	input  logic [ttop_pkg::TIME_W-1:0]   now_unscaled,
	input  logic [ttop_pkg::TIME_W-1:0]   now_scaled,
	output logic [ttop_pkg::TIME_W-1:0]   now_sel,
	output logic                          expired
);
	import ttop_pkg::*;

	logic [TIME_W-1:0] elapsed;

	assign now_sel = slot.scaled ? now_scaled : now_unscaled;
	// modulo 2^32 difference
	assign elapsed = now_sel - slot.start;
	assign expired = (elapsed >= slot.period);

endmodule

// ----- design/timer_table_oneshot_periodic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_oneshot_periodic
// Table of one-shot and periodic timers kept in creation order.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command plus both current times; rsp returns results,
//   each with a kind, a timer id and a last flag on the final one.
//   Create and clear (and unused commands) answer with a single result that
//   is registered in the transfer cycle.
//   Cancel and tick walk the slot RAM with a single expiry/id compare, one
//   entry per cycle while a stalled rsp does not hold them, compacting the
//   table in place as they go. req.ready stays low while a walk is in
//   progress.
//   Fired events are emitted during the walk; the last one is held back until
//   the walk ends so it can carry the last flag.
//   A stalled rsp freezes the walk at the next fired event; nothing is lost.
//   Reset empties the table and sets the next id to 1. No clearing pass is
//   needed: only entries below the count are ever used.
// ----------------------------------------------------------------------------
module timer_table_oneshot_periodic (
	input  logic              clk,
	input  logic              arst_n,
	ttop_req_if.sink          req,
	ttop_rsp_if.source        rsp
);
	import ttop_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  entry_count_q;
	logic [ID_W-1:0]   next_id_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  keep_q;
	logic              data_vld_s1;
	logic              pend_vld_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              is_tick_q;
	logic [ID_W-1:0]   target_q;
	logic [TIME_W-1:0] now_u_q;
	logic [TIME_W-1:0] now_s_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	slot_t             rdata_s1;
	slot_t             wdata;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic              rd_en;

	logic [TIME_W-1:0] now_sel;
	logic              expired;

	logic              out_free;
	logic              accept;
	logic              full;
	logic              fire;
	logic              stays;
	logic              stall;
	logic              push_en;
	kind_t             push_kind;
	logic [ID_W-1:0]   push_id;
	logic              push_last;

	ttop_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (NUM_TIMERS)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rdata_s1)
	);

	ttop_expire u_expire (
		.slot         (rdata_s1),
		.now_unscaled (now_u_q),
		.now_scaled   (now_s_q),
		.now_sel      (now_sel),
		.expired      (expired)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign full      = (entry_count_q == CNT_W'(NUM_TIMERS));

	assign fire  = is_tick_q && data_vld_s1 && expired;
	assign stays = is_tick_q ? (!expired || rdata_s1.periodic) : (rdata_s1.id != target_q);
	assign stall = fire && pend_vld_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		push_en   = 1'b0;
		push_kind = KIND_DONE;
		push_id   = '0;
		push_last = 1'b1;
		we        = 1'b0;
		waddr     = keep_q[IDX_W-1:0];
		wdata     = rdata_s1;
		rd_en     = 1'b0;
		if (fire && rdata_s1.periodic) begin
			wdata.start = now_sel;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_CREATE_ONESHOT, CMD_CREATE_PERIODIC: begin
							push_en = 1'b1;
							if (full) begin
								push_kind = KIND_FULL;
							end else begin
								we             = 1'b1;
								waddr          = entry_count_q[IDX_W-1:0];
								wdata.id       = next_id_q;
								wdata.period   = req.delay;
								wdata.start    = req.use_scaled ? req.now_scaled
									: req.now_unscaled;
								wdata.scaled   = req.use_scaled;
								wdata.periodic = (req.cmd == CMD_CREATE_PERIODIC);
								push_kind      = KIND_CREATED;
								push_id        = next_id_q;
							end
						end
						CMD_CANCEL, CMD_TICK: begin
							state_d = ST_SCAN;
						end
						default: begin
							push_en = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = !stall;
				if (data_vld_s1 && !stall) begin
					we = stays;
					// emit the previous fired event; the newest one stays pending
					if (fire && pend_vld_q) begin
						push_en   = 1'b1;
						push_kind = KIND_FIRED;
						push_id   = pend_id_q;
						push_last = 1'b0;
					end
				end
				if (!data_vld_s1 && rd_idx_q == entry_count_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push_en = 1'b1;
					if (!is_tick_q) begin
						push_kind = KIND_DONE;
					end else if (pend_vld_q) begin
						push_kind = KIND_FIRED;
						push_id   = pend_id_q;
					end else begin
						push_kind = KIND_NONE;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// table bookkeeping and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			next_id_q     <= ID_W'(1);
			rd_idx_q      <= '0;
			keep_q        <= '0;
			data_vld_s1   <= 1'b0;
			pend_vld_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q    <= '0;
						keep_q      <= '0;
						data_vld_s1 <= 1'b0;
						pend_vld_q  <= 1'b0;
						if ((req.cmd == CMD_CREATE_ONESHOT || req.cmd == CMD_CREATE_PERIODIC)
							&& !full) begin
							entry_count_q <= entry_count_q + CNT_W'(1);
							next_id_q     <= next_id_q + ID_W'(1);
						end
						if (req.cmd == CMD_CLEAR) begin
							entry_count_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (rd_idx_q < entry_count_q) begin
							rd_idx_q    <= rd_idx_q + CNT_W'(1);
							data_vld_s1 <= 1'b1;
						end else begin
							data_vld_s1 <= 1'b0;
						end
						if (data_vld_s1 && stays) begin
							keep_q <= keep_q + CNT_W'(1);
						end
						if (fire) begin
							pend_vld_q <= 1'b1;
						end
					end
					if (state_d == ST_FINISH) begin
						entry_count_q <= keep_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_tick_q <= (req.cmd == CMD_TICK);
			target_q  <= req.target_id;
			now_u_q   <= req.now_unscaled;
			now_s_q   <= req.now_scaled;
		end
		if (state_q == ST_SCAN && fire && !stall) begin
			pend_id_q <= rdata_s1.id;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_en) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			out_kind_q <= push_kind;
			out_id_q   <= push_id;
			out_last_q <= push_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.kind     = out_kind_q;
	assign rsp.timer_id = out_id_q;
	assign rsp.last     = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(NUM_TIMERS))
		else $error("entry count beyond table size");

	a_keep_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> keep_q <= rd_idx_q)
		else $error("compaction write pointer passed read pointer");

	a_walk_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && state_d == ST_FINISH |=> entry_count_q <= $past(entry_count_q))
		else $error("walk grew the table");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> out_free)
		else $error("result pushed over an untaken result");

endmodule
